[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL of the indirect block map walker.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define IBM_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define IBM_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/ibm_pkg.sv]
// Types and constants of the indirect block map walker.
// Used by the channel interfaces and the top level; depends on nothing.
package ibm_pkg;

    localparam int ROOT_SLOTS = 15;
    localparam int WORD_W     = 32;
    localparam int INDEX_W    = 11;
    localparam int SLOT_W     = 4;
    localparam int LOG2_W     = 4;
    localparam int MIN_LOG2   = 8;
    localparam int WIDE_W     = 34;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [LOG2_W-1:0]  log2_t;
    typedef logic [WIDE_W-1:0]  wide_t;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_RESP   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_RDERR = 2'd2,
        ST_BUSY  = 2'd3
    } status_t;

    typedef enum logic {
        KIND_REQ    = 1'b0,
        KIND_RESULT = 1'b1
    } kind_t;

    typedef struct packed {
        logic   out_kind;
        word_t  block_number;
        index_t word_index;
        logic [1:0] status;
    } result_t;

endpackage

[rtl/core/ibm_in_if.sv]
// Input channel of the walker: root loads, lookups and memory responses.
// Depends on ibm_pkg for the field types.
interface ibm_in_if;
    import ibm_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  action;
    slot_t       root_index;
    word_t       word_value;
    word_t       logical_block;
    logic        read_failed;

    modport source (output valid, action, root_index, word_value, logical_block,
                    read_failed, input ready);
    modport sink   (input valid, action, root_index, word_value, logical_block,
                    read_failed, output ready);
endinterface

[rtl/core/ibm_out_if.sv]
// Output channel of the walker: memory read requests and final translations.
// Depends on ibm_pkg for the field types.
interface ibm_out_if;
    import ibm_pkg::*;

    logic        valid;
    logic        ready;
    logic        out_kind;
    word_t       block_number;
    index_t      word_index;
    logic [1:0]  status;

    modport source (output valid, out_kind, block_number, word_index, status,
                    input ready);
    modport sink   (input valid, out_kind, block_number, word_index, status,
                    output ready);
endinterface

[rtl/core/indirect_block_map_walker.sv]
// Channel   Direction  Carries
// items     in         root loads, lookups, memory word responses
// results   out        read requests and translation results
// cfg       in         entries_log2 write (write enable and data)
//
// Each word is handled in the cycle it is accepted; its result is registered in
// the output or skid register, so one word per cycle flows while results are taken.
// A two-entry output stage (output register plus skid register) lets the
// input keep flowing while the output is stalled for one word.
// Reset clears the walk state, the output stage and sets entries_log2 to 8.
// Depends on ibm_pkg, ibm_in_if, ibm_out_if and assert_macros.svh.
`include "assert_macros.svh"

module indirect_block_map_walker #(
    parameter int DIRECT_SLOTS     = 12,
    parameter int MAX_ENTRIES_LOG2 = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ibm_in_if.sink               items,
    ibm_out_if.source            results,
    input  logic                 cfg_we,
    input  ibm_pkg::log2_t       cfg_wdata
);
    import ibm_pkg::*;

    // Configuration and walk state.
    log2_t      entries_log2_reg;
    word_t      root_reg [ROOT_SLOTS];
    logic [1:0] reads_left_reg, reads_left_next;
    logic       walk_busy_reg, walk_busy_next;
    index_t     mid_index_reg, mid_index_next;
    index_t     low_index_reg, low_index_next;

    // Output stage.
    logic       out_valid_reg;
    result_t    out_reg;
    logic       skid_valid_reg;
    result_t    skid_reg;

    logic       accept;
    logic       res_valid;
    result_t    res;
    action_t    act;

    log2_t      eff_k;
    logic [5:0] k_shift;
    logic [5:0] k2_shift;
    wide_t      lb_wide;
    wide_t      e_val;
    wide_t      mask_val;
    wide_t      lim2;
    wide_t      lim3;
    wide_t      rel1, rel2, rel3;
    slot_t      slot_sel;
    word_t      root_word;

    assign items.ready = !skid_valid_reg;
    assign accept      = items.valid && items.ready;
    assign act         = action_t'(items.action);

    // Clamp the entries register into the supported range.
    always_comb
    begin
        priority if (entries_log2_reg < log2_t'(MIN_LOG2))
            eff_k = log2_t'(MIN_LOG2);
        else if (entries_log2_reg > log2_t'(MAX_ENTRIES_LOG2))
            eff_k = log2_t'(MAX_ENTRIES_LOG2);
        else
            eff_k = entries_log2_reg;
    end

    assign k_shift  = {2'b00, eff_k};
    assign k2_shift = {1'b0, eff_k, 1'b0};
    assign lb_wide  = {2'b00, items.logical_block};
    assign e_val    = wide_t'(1) << k_shift;
    assign mask_val = e_val - wide_t'(1);
    assign lim2     = e_val << k_shift;
    assign lim3     = e_val << k2_shift;
    assign rel1     = lb_wide - wide_t'(DIRECT_SLOTS);
    assign rel2     = rel1 - e_val;
    assign rel3     = rel2 - lim2;

    // One root slot is read per word: a direct slot or one of the three indirect roots.
    always_comb
    begin
        priority if (lb_wide < wide_t'(DIRECT_SLOTS))
            slot_sel = items.logical_block[SLOT_W-1:0];
        else if (rel1 < e_val)
            slot_sel = slot_t'(DIRECT_SLOTS);
        else if (rel2 < lim2)
            slot_sel = slot_t'(DIRECT_SLOTS + 1);
        else
            slot_sel = slot_t'(DIRECT_SLOTS + 2);
    end

    assign root_word = root_reg[slot_sel];

    always_comb
    begin
        logic [1:0] left_dec;

        reads_left_next = reads_left_reg;
        walk_busy_next  = walk_busy_reg;
        mid_index_next  = mid_index_reg;
        low_index_next  = low_index_reg;
        res_valid       = 1'b0;
        res             = '0;
        left_dec        = (reads_left_reg != 2'd0) ? reads_left_reg - 2'd1 : 2'd0;

        if (accept)
        begin
            unique case (act)
                ACT_LOAD:
                begin
                end
                ACT_LOOKUP:
                begin
                    res_valid = 1'b1;
                    priority if (walk_busy_reg)
                    begin
                        res.out_kind = KIND_RESULT;
                        res.status   = ST_BUSY;
                    end
                    else if (lb_wide < wide_t'(DIRECT_SLOTS))
                    begin
                        res.out_kind     = KIND_RESULT;
                        res.block_number = root_word;
                        res.status       = ST_OK;
                    end
                    else if (rel1 < e_val)
                    begin
                        walk_busy_next   = 1'b1;
                        reads_left_next  = 2'd1;
                        res.out_kind     = KIND_REQ;
                        res.block_number = root_word;
                        res.word_index   = rel1[INDEX_W-1:0];
                    end
                    else if (rel2 < lim2)
                    begin
                        walk_busy_next   = 1'b1;
                        reads_left_next  = 2'd2;
                        low_index_next   = index_t'(rel2 & mask_val);
                        res.out_kind     = KIND_REQ;
                        res.block_number = root_word;
                        res.word_index   = index_t'(rel2 >> k_shift);
                    end
                    else if (rel3 < lim3)
                    begin
                        walk_busy_next   = 1'b1;
                        reads_left_next  = 2'd3;
                        mid_index_next   = index_t'((rel3 >> k_shift) & mask_val);
                        low_index_next   = index_t'(rel3 & mask_val);
                        res.out_kind     = KIND_REQ;
                        res.block_number = root_word;
                        res.word_index   = index_t'(rel3 >> k2_shift);
                    end
                    else
                    begin
                        res.out_kind = KIND_RESULT;
                        res.status   = ST_RANGE;
                    end
                end
                ACT_RESP:
                begin
                    // A response with no walk in progress is dropped.
                    if (walk_busy_reg)
                    begin
                        res_valid = 1'b1;
                        priority if (items.read_failed)
                        begin
                            walk_busy_next  = 1'b0;
                            reads_left_next = 2'd0;
                            res.out_kind    = KIND_RESULT;
                            res.status      = ST_RDERR;
                        end
                        else if (left_dec == 2'd0)
                        begin
                            walk_busy_next   = 1'b0;
                            reads_left_next  = 2'd0;
                            res.out_kind     = KIND_RESULT;
                            res.block_number = items.word_value;
                        end
                        else
                        begin
                            reads_left_next  = left_dec;
                            res.out_kind     = KIND_REQ;
                            res.block_number = items.word_value;
                            res.word_index   = (left_dec == 2'd2) ? mid_index_reg
                                                                  : low_index_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && act == ACT_LOAD && items.root_index < slot_t'(ROOT_SLOTS))
            root_reg[items.root_index] <= items.word_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_log2_reg <= log2_t'(MIN_LOG2);
            reads_left_reg   <= 2'd0;
            walk_busy_reg    <= 1'b0;
            mid_index_reg    <= '0;
            low_index_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                entries_log2_reg <= cfg_wdata;
            reads_left_reg <= reads_left_next;
            walk_busy_reg  <= walk_busy_next;
            mid_index_reg  <= mid_index_next;
            low_index_reg  <= low_index_next;
        end
    end

    // Output register with a skid register behind it.
    logic out_free;
    assign out_free = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_reg <= skid_valid_reg ? skid_reg : res;
        else if (res_valid)
            skid_reg <= res;
    end

    assign results.valid        = out_valid_reg;
    assign results.out_kind     = out_reg.out_kind;
    assign results.block_number = out_reg.block_number;
    assign results.word_index   = out_reg.word_index;
    assign results.status       = out_reg.status;

    `IBM_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `IBM_ASSERT_SAME(a_busy_matches_count, 1'b1, walk_busy_reg == (reads_left_reg != 2'd0))
    `IBM_ASSERT_NEXT(a_busy_lookup_keeps_walk, accept && act == ACT_LOOKUP && walk_busy_reg,
                     walk_busy_reg)
    `IBM_ASSERT_NEXT(a_stray_resp_no_walk, accept && act == ACT_RESP && !walk_busy_reg,
                     !walk_busy_reg)

endmodule
